// File: rtl/ocs_pkg.sv
// Shared constants, status codes, controller states and the command/status
// structs of the offset counting sorter.
// No dependencies.
`timescale 1ns / 1ps

package ocs_pkg;

    localparam int MAX_ITEMS   = 64;
    localparam int COUNT_DEPTH = 256;
    localparam int VALUE_BITS  = 16;

    localparam int ITEM_AW = $clog2(MAX_ITEMS);
    localparam int ITEM_CW = $clog2(MAX_ITEMS + 1);
    localparam int CNT_AW  = $clog2(COUNT_DEPTH);
    // one spare top bit so a count-down past zero shows up in the MSB
    localparam int IDX_W   = ((ITEM_CW > CNT_AW) ? ITEM_CW : CNT_AW) + 1;
    localparam int DIFF_W  = ((VALUE_BITS + 1) > (CNT_AW + 2)) ? (VALUE_BITS + 1) : (CNT_AW + 2);

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_ITEMS = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_CLEAR,
        S_CNT_RD,
        S_CNT_OFS,
        S_CNT_WR,
        S_PFX,
        S_PFX_DRAIN,
        S_PLC_RD,
        S_PLC_OFS,
        S_PLC_WR,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic    load;
        logic    start_sort;
        logic    idx_clr;
        logic    idx_top;
        logic    idx_inc;
        logic    idx_dec;
        logic    clr_wr;
        logic    item_rd;
        logic    cnt_rd;
        logic    cnt_upd;
        logic    pfx_rd;
        logic    place_upd;
        logic    emit_rd;
        logic    err_out;
        status_t err_st;
        logic    end_set;
    } cmd_t;

    typedef struct packed {
        logic overflow;
        logic range_wide;
        logic idx_eq_range;
        logic idx_eq_cnt;
        logic idx_eq_last;
        logic idx_neg;
    } stat_t;

endpackage

// File: rtl/ocs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module ocs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/ocs_ctrl.sv
// Sequencer of the sorter: load, check, clear, count, prefix, place, emit.
// Depends on ocs_pkg.
`timescale 1ns / 1ps

module ocs_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          last_item,
    input  ocs_pkg::stat_t stat,
    output logic          busy,
    output ocs_pkg::cmd_t  cmd
);
    import ocs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && last_item)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.overflow || stat.range_wide)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                if (stat.idx_eq_range)
                begin
                    state_next = S_CNT_RD;
                end
            end
            S_CNT_RD:    state_next = S_CNT_OFS;
            S_CNT_OFS:   state_next = S_CNT_WR;
            S_CNT_WR:
            begin
                state_next = stat.idx_eq_cnt ? S_PFX : S_CNT_OFS;
            end
            S_PFX:
            begin
                if (stat.idx_eq_range)
                begin
                    state_next = S_PFX_DRAIN;
                end
            end
            S_PFX_DRAIN: state_next = S_PLC_RD;
            S_PLC_RD:    state_next = S_PLC_OFS;
            S_PLC_OFS:   state_next = S_PLC_WR;
            S_PLC_WR:
            begin
                state_next = stat.idx_neg ? S_EMIT : S_PLC_OFS;
            end
            S_EMIT:
            begin
                if (stat.idx_eq_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            S_CHECK:
            begin
                priority if (stat.overflow)
                begin
                    cmd.err_out = 1'b1;
                    cmd.err_st  = ST_ITEMS;
                    cmd.end_set = 1'b1;
                end
                else if (stat.range_wide)
                begin
                    cmd.err_out = 1'b1;
                    cmd.err_st  = ST_RANGE;
                    cmd.end_set = 1'b1;
                end
                else
                begin
                    cmd.start_sort = 1'b1;
                    cmd.idx_clr    = 1'b1;
                end
            end
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.idx_eq_range)
                begin
                    cmd.idx_clr = 1'b1;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_CNT_RD:
            begin
                cmd.item_rd = 1'b1;
            end
            S_CNT_OFS:
            begin
                cmd.cnt_rd  = 1'b1;
                cmd.idx_inc = 1'b1;
            end
            S_CNT_WR:
            begin
                cmd.cnt_upd = 1'b1;
                if (stat.idx_eq_cnt)
                begin
                    cmd.idx_clr = 1'b1;
                end
                else
                begin
                    cmd.item_rd = 1'b1;
                end
            end
            S_PFX:
            begin
                cmd.pfx_rd = 1'b1;
                if (!stat.idx_eq_range)
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_PFX_DRAIN:
            begin
                cmd.idx_top = 1'b1;
            end
            S_PLC_RD:
            begin
                cmd.item_rd = 1'b1;
            end
            S_PLC_OFS:
            begin
                cmd.cnt_rd  = 1'b1;
                cmd.idx_dec = 1'b1;
            end
            S_PLC_WR:
            begin
                cmd.place_upd = 1'b1;
                if (stat.idx_neg)
                begin
                    cmd.idx_clr = 1'b1;
                end
                else
                begin
                    cmd.item_rd = 1'b1;
                end
            end
            S_EMIT:
            begin
                cmd.emit_rd = 1'b1;
                cmd.idx_inc = 1'b1;
                if (stat.idx_eq_last)
                begin
                    cmd.end_set = 1'b1;
                end
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// File: rtl/ocs_datapath.sv
// Datapath of the sorter: item, count and sorted RAMs, min/max tracking,
// index counter, prefix accumulator and result registers.
// Depends on ocs_pkg and ocs_ram.
`timescale 1ns / 1ps

module ocs_datapath (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic signed [ocs_pkg::VALUE_BITS-1:0]    value,
    input  ocs_pkg::cmd_t                            cmd,
    output ocs_pkg::stat_t                           stat,
    output logic                                     result_valid,
    output logic signed [ocs_pkg::VALUE_BITS-1:0]    sorted_value,
    output logic                                     last_result,
    output logic [1:0]                               status
);
    import ocs_pkg::*;

    logic signed [VALUE_BITS-1:0] min_reg, min_next;
    logic signed [VALUE_BITS-1:0] max_reg, max_next;
    logic [ITEM_CW-1:0]           count_reg, count_next;
    logic                         ovf_reg, ovf_next;
    logic [IDX_W-1:0]             idx_reg, idx_next;

    logic [CNT_AW-1:0]     range_reg;
    logic [ITEM_CW-1:0]    sum_reg;
    logic [VALUE_BITS-1:0] x_reg;
    logic [CNT_AW-1:0]     off_reg;
    logic                  pfx_v_reg;
    logic [CNT_AW-1:0]     pfx_addr_reg;
    logic                  emit_v_reg;
    logic                  emit_last_reg;
    logic                  err_v_reg;
    status_t               err_st_reg;

    logic                         room;
    logic                         first;
    logic signed [DIFF_W-1:0]     diff;
    logic signed [DIFF_W-1:0]     off_full;
    logic [CNT_AW-1:0]            off_now;
    logic [VALUE_BITS-1:0]        item_rdata;
    logic [VALUE_BITS-1:0]        sorted_rdata;
    logic [ITEM_CW-1:0]           cnt_rdata;
    logic                         cnt_nonzero;
    logic [ITEM_CW-1:0]           cnt_dec;
    logic                         cnt_we;
    logic [CNT_AW-1:0]            cnt_waddr;
    logic [ITEM_CW-1:0]           cnt_wdata;
    logic [CNT_AW-1:0]            cnt_raddr;
    logic                         sorted_we;

    assign room  = count_reg < ITEM_CW'(MAX_ITEMS);
    assign first = (count_reg == '0) && !ovf_reg;

    assign diff     = DIFF_W'(max_reg) - DIFF_W'(min_reg);
    assign off_full = DIFF_W'($signed(item_rdata)) - DIFF_W'(min_reg);
    assign off_now  = off_full[CNT_AW-1:0];

    assign stat.overflow     = ovf_reg;
    assign stat.range_wide   = $unsigned(diff) >= DIFF_W'(COUNT_DEPTH);
    assign stat.idx_eq_range = idx_reg == IDX_W'(range_reg);
    assign stat.idx_eq_cnt   = idx_reg == IDX_W'(count_reg);
    assign stat.idx_eq_last  = idx_reg == (IDX_W'(count_reg) - IDX_W'(1));
    assign stat.idx_neg      = idx_reg[IDX_W-1];

    always_comb
    begin
        min_next   = min_reg;
        max_next   = max_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        priority if (cmd.end_set)
        begin
            min_next   = '0;
            max_next   = '0;
            count_next = '0;
            ovf_next   = 1'b0;
        end
        else if (cmd.load)
        begin
            if (first)
            begin
                min_next = value;
                max_next = value;
            end
            else
            begin
                if (value < min_reg)
                begin
                    min_next = value;
                end
                if (value > max_reg)
                begin
                    max_next = value;
                end
            end
            if (room)
            begin
                count_next = count_reg + ITEM_CW'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_comb
    begin
        priority if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_top)
        begin
            idx_next = IDX_W'(count_reg) - IDX_W'(1);
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
        else if (cmd.idx_dec)
        begin
            idx_next = idx_reg - IDX_W'(1);
        end
        else
        begin
            idx_next = idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg    <= '0;
            max_reg    <= '0;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            idx_reg    <= '0;
            pfx_v_reg  <= 1'b0;
            emit_v_reg <= 1'b0;
            err_v_reg  <= 1'b0;
        end
        else
        begin
            min_reg    <= min_next;
            max_reg    <= max_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            idx_reg    <= idx_next;
            pfx_v_reg  <= cmd.pfx_rd;
            emit_v_reg <= cmd.emit_rd;
            err_v_reg  <= cmd.err_out;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_sort)
        begin
            range_reg <= diff[CNT_AW-1:0];
        end
        if (cmd.start_sort)
        begin
            sum_reg <= '0;
        end
        else if (pfx_v_reg)
        begin
            sum_reg <= sum_reg + cnt_rdata;
        end
        if (cmd.cnt_rd)
        begin
            x_reg   <= item_rdata;
            off_reg <= off_now;
        end
        pfx_addr_reg <= idx_reg[CNT_AW-1:0];
        if (cmd.emit_rd)
        begin
            emit_last_reg <= stat.idx_eq_last;
        end
        if (cmd.err_out)
        begin
            err_st_reg <= cmd.err_st;
        end
    end

    // count store write port: clear, count up, prefix write-back, place count-down
    assign cnt_nonzero = cnt_rdata != '0;
    assign cnt_dec     = cnt_rdata - ITEM_CW'(1);

    always_comb
    begin
        cnt_we    = 1'b0;
        cnt_waddr = off_reg;
        cnt_wdata = cnt_dec;
        priority if (cmd.clr_wr)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = idx_reg[CNT_AW-1:0];
            cnt_wdata = '0;
        end
        else if (cmd.cnt_upd)
        begin
            cnt_we    = 1'b1;
            cnt_wdata = cnt_rdata + ITEM_CW'(1);
        end
        else if (cmd.place_upd)
        begin
            cnt_we    = cnt_nonzero;
            cnt_wdata = cnt_dec;
        end
        else if (pfx_v_reg)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = pfx_addr_reg;
            cnt_wdata = sum_reg + cnt_rdata;
        end
        else
        begin
            cnt_we = 1'b0;
        end
    end

    assign cnt_raddr = cmd.pfx_rd ? idx_reg[CNT_AW-1:0] : off_now;
    assign sorted_we = cmd.place_upd && cnt_nonzero;

    ocs_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_ITEMS)
    ) u_item_ram (
        .clk     (clk),
        .wr_en   (cmd.load && room),
        .wr_addr (count_reg[ITEM_AW-1:0]),
        .wr_data (value),
        .rd_en   (cmd.item_rd),
        .rd_addr (idx_reg[ITEM_AW-1:0]),
        .rd_data (item_rdata)
    );

    ocs_ram #(
        .WIDTH (ITEM_CW),
        .DEPTH (COUNT_DEPTH)
    ) u_count_ram (
        .clk     (clk),
        .wr_en   (cnt_we),
        .wr_addr (cnt_waddr),
        .wr_data (cnt_wdata),
        .rd_en   (cmd.cnt_rd || cmd.pfx_rd),
        .rd_addr (cnt_raddr),
        .rd_data (cnt_rdata)
    );

    ocs_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_ITEMS)
    ) u_sorted_ram (
        .clk     (clk),
        .wr_en   (sorted_we),
        .wr_addr (cnt_dec[ITEM_AW-1:0]),
        .wr_data (x_reg),
        .rd_en   (cmd.emit_rd),
        .rd_addr (idx_reg[ITEM_AW-1:0]),
        .rd_data (sorted_rdata)
    );

    assign result_valid = emit_v_reg || err_v_reg;
    assign sorted_value = emit_v_reg ? $signed(sorted_rdata) : '0;
    assign last_result  = err_v_reg || (emit_v_reg && emit_last_reg);
    assign status       = err_v_reg ? err_st_reg : ST_OK;

endmodule

// File: rtl/offset_counting_sorter_top.sv
// Top level of the offset counting sorter: controller plus datapath.
// Depends on ocs_pkg, ocs_ctrl, ocs_datapath.
//
// Usage:
//   Input: present value/last_item with start; the item transfers on a rising
//   edge where start is high and busy is low. While a set is loading busy stays
//   low, so one item transfers per cycle. The item with last_item set closes
//   the set and raises busy on the next cycle.
//   Output: each result shows for one cycle with result_valid high; the
//   receiver cannot stall, so results are never held. Sorted results come out
//   on consecutive cycles in ascending order, last_result on the final one.
//   Error sets (more than MAX_ITEMS items, or max - min + 1 above COUNT_DEPTH)
//   give one result with sorted_value 0, last_result 1 and the fault in
//   status, registered from the check state that follows the closing item.
//   Sequence for a good set after the closing item: check, count-store clear
//   over the range r = max - min, count, prefix, place, emit; the count,
//   prefix and place passes are bound by the single read and write port of
//   the count RAM. The last result shows in the first cycle with busy low.
//   Reset: asynchronous, clears the set state; the count RAM is cleared over
//   the used range at the start of every sort, so no sweep after reset.
`timescale 1ns / 1ps

module offset_counting_sorter_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [ocs_pkg::VALUE_BITS-1:0] value,
    input  logic                                  last_item,
    output logic                                  result_valid,
    output logic signed [ocs_pkg::VALUE_BITS-1:0] sorted_value,
    output logic                                  last_result,
    output logic [1:0]                            status
);
    import ocs_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    ocs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .last_item (last_item),
        .stat      (stat),
        .busy      (busy),
        .cmd       (cmd)
    );

    ocs_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .value        (value),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .sorted_value (sorted_value),
        .last_result  (last_result),
        .status       (status)
    );

endmodule

// File: rtl/ocs_checker.sv
// Port-level checks on the sorter top level, attached by bind.
// Depends on ocs_pkg and offset_counting_sorter_top.
`timescale 1ns / 1ps

module ocs_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  start,
    input logic                                  busy,
    input logic                                  last_item,
    input logic                                  result_valid,
    input logic signed [ocs_pkg::VALUE_BITS-1:0] sorted_value,
    input logic                                  last_result,
    input logic [1:0]                            status
);
    import ocs_pkg::*;

    // an unmarked item keeps the set loading
    a_load_continues: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !last_item |=> !busy)
        else $error("busy rose after an unmarked item");

    // the closing item starts the run
    a_close_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && last_item |=> busy)
        else $error("busy did not rise after the closing item");

    // error result is a single, final result
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status != ST_OK) |-> last_result)
        else $error("error result without last marker");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status != ST_OK) |-> (sorted_value == '0))
        else $error("error result with nonzero value");

    // sorted results are emitted back to back until the last one
    a_emit_burst: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_result |=> result_valid)
        else $error("gap inside a sorted result burst");

endmodule

bind offset_counting_sorter_top ocs_checker u_ocs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .last_item    (last_item),
    .result_valid (result_valid),
    .sorted_value (sorted_value),
    .last_result  (last_result),
    .status       (status)
);
